// ----- rtl/bprd_pkg.sv -----
// ============================================================================
// bprd_pkg
// Types, constants and register map shared by the beacon proximity detector.
// ============================================================================
`default_nettype none

package bprd_pkg;

    localparam int NUM_BEACONS = 2;
    localparam int AVG_WINDOW  = 8;

    localparam int ADDR_W  = 48;
    localparam int RSSI_W  = 8;
    localparam int LEVEL_W = 8;
    localparam int CNT_W   = 8;
    localparam int TIMER_W = 16;
    localparam int BIDX_W  = 1;
    localparam int POS_W   = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int SUM_W   = LEVEL_W + $clog2(AVG_WINDOW + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ADDR_W;

    localparam logic [LEVEL_W-1:0] RING_FILL = LEVEL_W'(100);
    localparam logic [SUM_W-1:0]   SUM_FILL  = SUM_W'(AVG_WINDOW * 100);

    localparam logic OP_ADVERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTER_LEVEL   = 3'd0,
        REG_DEBOUNCE      = 3'd1,
        REG_LEAVE_LEVEL   = 3'd2,
        REG_LOSS_TIMEOUT  = 3'd3,
        REG_BEACON_ADDR_A = 3'd4,
        REG_BEACON_ADDR_B = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        DOOR_NONE  = 2'd0,
        DOOR_OPEN  = 2'd1,
        DOOR_CLOSE = 2'd2
    } t_door;

    typedef enum logic [1:0] {
        KIND_HIT  = 2'd0,
        KIND_MISS = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    typedef struct packed {
        logic [LEVEL_W-1:0]          enter_level;
        logic [CNT_W-1:0]            debounce_count;
        logic [LEVEL_W-1:0]          leave_level;
        logic [TIMER_W-1:0]          loss_timeout_ticks;
        logic [1:0][ADDR_W-1:0]      beacon_addr;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enter_level:        LEVEL_W'(60),
        debounce_count:     CNT_W'(3),
        leave_level:        LEVEL_W'(80),
        loss_timeout_ticks: TIMER_W'(1000),
        beacon_addr:        {ADDR_W'(48'd35330487157002), ADDR_W'(48'd35330487156998)}
    };

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  mac;
        logic [RSSI_W-1:0]  rssi_raw;
    } t_in;

    typedef struct packed {
        logic               matched;
        logic [BIDX_W-1:0]  beacon_index;
        logic [LEVEL_W-1:0] average_level;
        logic [1:0]         present_count;
        t_door              door_cmd;
    } t_out;

    typedef struct packed {
        t_kind              kind;
        logic [BIDX_W-1:0]  beacon_index;
        logic [LEVEL_W-1:0] level;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/bprd_front.sv -----
// ============================================================================
// bprd_front
// Accepts words, matches the advertiser address and queues classified words.
// ============================================================================
`default_nettype none

module bprd_front import bprd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    input  wire t_in  i_in_item,
    output logic      full,
    input  wire t_cfg i_cfg,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    t_cmd       cmd_new;
    logic       hit;
    logic [BIDX_W-1:0] hit_idx;
    logic       acc;
    logic       take;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int b = NUM_BEACONS - 1; b >= 0; b--) begin
            if (i_in_item.mac == i_cfg.beacon_addr[b]) begin
                hit     = 1'b1;
                hit_idx = BIDX_W'(b);
            end
        end
        cmd_new.level        = LEVEL_W'(0) - i_in_item.rssi_raw;
        cmd_new.beacon_index = hit_idx;
        if (i_in_item.op == OP_TICK) begin
            cmd_new.kind = KIND_TICK;
        end else if (hit) begin
            cmd_new.kind = KIND_HIT;
        end else begin
            cmd_new.kind = KIND_MISS;
        end
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign acc         = push && !full;
    assign take        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (acc) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr_ptr] <= cmd_new;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bprd_back.sv -----
// ============================================================================
// bprd_back
// Per-beacon averaging, debounce and loss timers; queues result words.
// ============================================================================
`default_nettype none

module bprd_back import bprd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_take,
    output logic      empty,
    output t_out      o_out_item,
    input  wire logic pop
);

    logic [LEVEL_W-1:0] r_ring  [NUM_BEACONS][AVG_WINDOW];
    logic [POS_W-1:0]   r_pos   [NUM_BEACONS];
    logic [SUM_W-1:0]   r_sum   [NUM_BEACONS];
    logic [CNT_W-1:0]   r_cnt   [NUM_BEACONS];
    logic [TIMER_W-1:0] r_timer [NUM_BEACONS];

    logic [LEVEL_W-1:0] n_ring  [NUM_BEACONS][AVG_WINDOW];
    logic [POS_W-1:0]   n_pos   [NUM_BEACONS];
    logic [SUM_W-1:0]   n_sum   [NUM_BEACONS];
    logic [CNT_W-1:0]   n_cnt   [NUM_BEACONS];
    logic [TIMER_W-1:0] n_timer [NUM_BEACONS];

    t_out       r_res [2];
    logic       r_res_wr;
    logic       r_res_rd;
    logic [1:0] r_res_cnt;

    logic [BIDX_W-1:0]  bi;
    logic [LEVEL_W-1:0] old_smp;
    logic [SUM_W-1:0]   sum_new;
    logic [LEVEL_W-1:0] avg_new;
    logic [CNT_W-1:0]   cnt_old;
    logic [CNT_W-1:0]   cnt_upd;
    logic [TIMER_W-1:0] tmr_inc;
    logic [TIMER_W-1:0] limit;
    logic [LEVEL_W-1:0] avg;
    logic [1:0]         present;
    t_door              flag;
    t_out               res;
    logic               res_pop;
    logic               take;

    assign res_pop    = pop && (r_res_cnt != 2'd0);
    assign take       = i_cmd_valid && ((r_res_cnt != 2'd2) || res_pop);
    assign o_cmd_take = take;
    assign empty      = (r_res_cnt == 2'd0);
    assign o_out_item = r_res[r_res_rd];

    assign bi      = i_cmd.beacon_index;
    assign old_smp = r_ring[bi][r_pos[bi]];
    assign sum_new = r_sum[bi] - SUM_W'(old_smp) + SUM_W'(i_cmd.level);
    assign avg_new = LEVEL_W'(sum_new / AVG_WINDOW);
    assign cnt_old = r_cnt[bi];
    assign limit   = (i_cfg.loss_timeout_ticks == '0) ? TIMER_W'(1)
                                                      : i_cfg.loss_timeout_ticks;

    always_comb begin
        n_ring  = r_ring;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_timer = r_timer;
        flag    = DOOR_NONE;
        avg     = '0;
        cnt_upd = cnt_old;
        tmr_inc = '0;
        present = '0;
        if (take) begin
            unique case (i_cmd.kind)
                KIND_HIT: begin
                    n_ring[bi][r_pos[bi]] = i_cmd.level;
                    n_pos[bi]   = (r_pos[bi] == POS_W'(AVG_WINDOW - 1)) ? '0
                                                                        : r_pos[bi] + 1'b1;
                    n_sum[bi]   = sum_new;
                    n_timer[bi] = '0;
                    avg         = avg_new;
                    if (cnt_old < i_cfg.debounce_count && avg_new > i_cfg.enter_level) begin
                        n_cnt[bi] = '0;
                    end else begin
                        if (avg_new < i_cfg.leave_level) begin
                            cnt_upd = (cnt_old < i_cfg.debounce_count) ? cnt_old + 1'b1 : cnt_old;
                        end else begin
                            cnt_upd = '0;
                        end
                        n_cnt[bi] = cnt_upd;
                        if (cnt_old != cnt_upd) begin
                            if (cnt_upd == i_cfg.debounce_count) begin
                                flag = DOOR_OPEN;
                            end
                            if (cnt_upd == '0) begin
                                flag = DOOR_CLOSE;
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    for (int b = 0; b < NUM_BEACONS; b++) begin
                        tmr_inc = (r_timer[b] == '1) ? r_timer[b] : r_timer[b] + 1'b1;
                        if (tmr_inc >= limit) begin
                            n_timer[b] = '0;
                            n_cnt[b]   = '0;
                            if (r_cnt[b] != '0) begin
                                flag = DOOR_CLOSE;
                            end
                        end else begin
                            n_timer[b] = tmr_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        for (int b = 0; b < NUM_BEACONS; b++) begin
            if (n_cnt[b] == i_cfg.debounce_count) begin
                present = present + 2'd1;
            end
        end
        res.matched       = (i_cmd.kind == KIND_HIT);
        res.beacon_index  = (i_cmd.kind == KIND_HIT) ? bi : '0;
        res.average_level = avg;
        res.present_count = present;
        if (flag == DOOR_OPEN && present == 2'd1) begin
            res.door_cmd = DOOR_OPEN;
        end else if (flag == DOOR_CLOSE && present == 2'd0) begin
            res.door_cmd = DOOR_CLOSE;
        end else begin
            res.door_cmd = DOOR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BEACONS; b++) begin
                for (int i = 0; i < AVG_WINDOW; i++) begin
                    r_ring[b][i] <= RING_FILL;
                end
                r_pos[b]   <= '0;
                r_sum[b]   <= SUM_FILL;
                r_cnt[b]   <= '0;
                r_timer[b] <= '0;
            end
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            r_ring  <= n_ring;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_timer <= n_timer;
            if (take) begin
                r_res_wr <= ~r_res_wr;
            end
            if (res_pop) begin
                r_res_rd <= ~r_res_rd;
            end
            r_res_cnt <= r_res_cnt + {1'b0, take} - {1'b0, res_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res[r_res_wr] <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/beacon_rssi_proximity_detector.sv -----
// ============================================================================
// beacon_rssi_proximity_detector
// Tracks beacon proximity from advert RSSI and issues door open/close words.
// ----------------------------------------------------------------------------
// Input queue: a word (advert or tick) is taken when push is high and full low.
// Result queue: one result word per input word, in order; the oldest is shown
// while empty is low and leaves when pop is high.
// Config: i_cfg_we writes i_cfg_wdata to register i_cfg_index at once; the
// user must write only while no word is in flight; the block does not enforce
// it. Unknown indexes are ignored. Throughput: one word per cycle while the
// result queue has room or is popped; the back end updates ring, running sum,
// debounce counter and idle timers together for each word.
// Front and back are joined by a 2-entry word queue; results sit in a 2-entry
// queue. When pop stalls, both queues fill and full rises after four words.
// Reset: queues empty, rings 100, sums full window, counters and timers zero,
// registers at their defaults.
// ============================================================================
`default_nettype none

module beacon_rssi_proximity_detector import bprd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    input  wire t_in                   i_in_item,
    output logic                       full,
    output logic                       empty,
    output t_out                       o_out_item,
    input  wire logic                  pop,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENTER_LEVEL:   r_cfg.enter_level        <= i_cfg_wdata[LEVEL_W-1:0];
                REG_DEBOUNCE:      r_cfg.debounce_count     <= i_cfg_wdata[CNT_W-1:0];
                REG_LEAVE_LEVEL:   r_cfg.leave_level        <= i_cfg_wdata[LEVEL_W-1:0];
                REG_LOSS_TIMEOUT:  r_cfg.loss_timeout_ticks <= i_cfg_wdata[TIMER_W-1:0];
                REG_BEACON_ADDR_A: r_cfg.beacon_addr[0]     <= i_cfg_wdata[ADDR_W-1:0];
                REG_BEACON_ADDR_B: r_cfg.beacon_addr[1]     <= i_cfg_wdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bprd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (i_in_item),
        .full        (full),
        .i_cfg       (r_cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    bprd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .o_out_item  (o_out_item),
        .pop         (pop)
    );

    a_open_one_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.door_cmd == DOOR_OPEN) |-> o_out_item.present_count == 2'd1)
        else $error("open command without exactly one beacon present");

    a_close_none_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.door_cmd == DOOR_CLOSE) |-> o_out_item.present_count == 2'd0)
        else $error("close command with a beacon present");

    a_unmatched_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.matched)
            |-> (o_out_item.beacon_index == '0 && o_out_item.average_level == '0))
        else $error("unmatched result carries beacon data");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty) |-> ##2 !empty)
        else $error("accepted word did not reach the result queue");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ============================================================================
// testbench
// Checks beacon_rssi_proximity_detector against a cycle-free model of its
// ring averages, debounce counters, idle timers and door decision. A short
// list of directed words goes first, then phases of random words, each phase
// under a fresh register setting. Queue sides idle at random but in phase 4.
// ============================================================================

module testbench;
    import bprd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 94;

    typedef struct packed {
        bit                    is_cfg;
        t_reg_idx              idx;
        logic [ADDR_W-1:0]     data;
        t_in                   word;
        bit                    pinned;
        t_out                  want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  push      = 1'b0;
    t_in                   in_item   = '0;
    logic                  full;
    logic                  empty;
    t_out                  out_item;
    logic                  pop       = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // model state and register copy
    logic [LEVEL_W-1:0] lvl_ring [NUM_BEACONS][AVG_WINDOW];
    int                 ring_ptr [NUM_BEACONS];
    int                 lvl_sum [NUM_BEACONS];
    logic [CNT_W-1:0]   near_cnt [NUM_BEACONS];
    int                 quiet_ticks [NUM_BEACONS];
    logic [7:0]         thr_enter, thr_debounce, thr_leave;
    logic [15:0]        lost_after;
    logic [ADDR_W-1:0]  tag_addr [NUM_BEACONS];

    t_out pending_results [$];
    int   mismatches  = 0;
    int   words_out   = 0;
    int   cycle_count = 0;
    bit   steady      = 1'b0;

    beacon_rssi_proximity_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (in_item),
        .full        (full),
        .empty       (empty),
        .o_out_item  (out_item),
        .pop         (pop),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    function automatic t_out predict_detector(input t_in w);
        t_out       r;
        t_door      flag;
        logic [7:0] lvl, was;
        int         hit, limit, n;
        r    = '0;
        flag = DOOR_NONE;
        hit  = -1;
        if (w.op == OP_ADVERT) begin
            for (int b = 0; b < NUM_BEACONS; b++) begin
                if (hit < 0 && w.mac == tag_addr[b]) hit = b;
            end
            if (hit >= 0) begin
                lvl = 8'd0 - w.rssi_raw;
                was = near_cnt[hit];
                lvl_sum[hit] = lvl_sum[hit] - lvl_ring[hit][ring_ptr[hit]] + lvl;
                lvl_ring[hit][ring_ptr[hit]] = lvl;
                ring_ptr[hit] = (ring_ptr[hit] + 1) % AVG_WINDOW;
                quiet_ticks[hit] = 0;
                r.matched       = 1'b1;
                r.beacon_index  = hit[0];
                r.average_level = 8'(lvl_sum[hit] / AVG_WINDOW);
                if (was < thr_debounce && r.average_level > thr_enter) begin
                    near_cnt[hit] = '0;
                end else begin
                    if (r.average_level < thr_leave) begin
                        if (was < thr_debounce) near_cnt[hit] = was + 8'd1;
                    end else begin
                        near_cnt[hit] = '0;
                    end
                    if (near_cnt[hit] != was) begin
                        if (near_cnt[hit] == thr_debounce) flag = DOOR_OPEN;
                        if (near_cnt[hit] == 0) flag = DOOR_CLOSE;
                    end
                end
            end
        end else begin
            limit = (lost_after == 0) ? 1 : int'(lost_after);
            for (int b = 0; b < NUM_BEACONS; b++) begin
                if (quiet_ticks[b] < 65535) quiet_ticks[b]++;
                if (quiet_ticks[b] >= limit) begin
                    quiet_ticks[b] = 0;
                    if (near_cnt[b] != 0) flag = DOOR_CLOSE;
                    near_cnt[b] = '0;
                end
            end
        end
        n = 0;
        for (int b = 0; b < NUM_BEACONS; b++) begin
            if (near_cnt[b] == thr_debounce) n++;
        end
        r.present_count = 2'(n);
        if (flag == DOOR_OPEN && n == 1) r.door_cmd = DOOR_OPEN;
        else if (flag == DOOR_CLOSE && n == 0) r.door_cmd = DOOR_CLOSE;
        else r.door_cmd = DOOR_NONE;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < 100)
            $display("mismatch at result %0d, %s: got %0h, expected %0h",
                     words_out, what, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        pop <= steady || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && empty === 1'b0 && pop) begin
            words_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("word with none expected", 16'd1, 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_item.matched !== want.matched)
                    report_mismatch("matched", 16'(out_item.matched), 16'(want.matched));
                if (out_item.beacon_index !== want.beacon_index)
                    report_mismatch("beacon_index", 16'(out_item.beacon_index),
                                    16'(want.beacon_index));
                if (out_item.average_level !== want.average_level)
                    report_mismatch("average_level", 16'(out_item.average_level),
                                    16'(want.average_level));
                if (out_item.present_count !== want.present_count)
                    report_mismatch("present_count", 16'(out_item.present_count),
                                    16'(want.present_count));
                if (out_item.door_cmd !== want.door_cmd)
                    report_mismatch("door_cmd", 16'(out_item.door_cmd),
                                    16'(want.door_cmd));
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input t_in w, input bit pinned, input t_out want);
        t_out guess;
        while (!steady && $urandom_range(0, 99) < 24) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= w;
        do @(posedge i_clk); while (full !== 1'b0);
        guess = predict_detector(w);
        pending_results.push_back(pinned ? want : guess);
        @(negedge i_clk);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input t_reg_idx idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ENTER_LEVEL:   thr_enter    = val[7:0];
            REG_DEBOUNCE:      thr_debounce = val[7:0];
            REG_LEAVE_LEVEL:   thr_leave    = val[7:0];
            REG_LOSS_TIMEOUT:  lost_after   = val[15:0];
            REG_BEACON_ADDR_A: tag_addr[0]  = val;
            REG_BEACON_ADDR_B: tag_addr[1]  = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_row word_row(input logic op, input logic [ADDR_W-1:0] mac,
                                      input logic [RSSI_W-1:0] rssi);
        t_row r;
        r = '0;
        r.word.op       = op;
        r.word.mac      = mac;
        r.word.rssi_raw = rssi;
        return r;
    endfunction

    function automatic t_row cfg_row(input t_reg_idx idx, input logic [ADDR_W-1:0] val);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = val;
        return r;
    endfunction

    function automatic t_row pin(input t_row r, input t_out want);
        r.pinned = 1'b1;
        r.want   = want;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    initial begin : stimulus
        t_row              plan [$];
        t_out              blank;
        t_in               w;
        logic [ADDR_W-1:0] addr_a, addr_b, aa, ab;
        logic [7:0]        ent, deb, lev;
        logic [15:0]       tmo;
        int                trend [NUM_BEACONS];
        int                pick, b, lvl;

        for (int i = 0; i < NUM_BEACONS; i++) begin
            for (int j = 0; j < AVG_WINDOW; j++) lvl_ring[i][j] = RING_FILL;
            ring_ptr[i]    = 0;
            lvl_sum[i]     = AVG_WINDOW * 100;
            near_cnt[i]    = '0;
            quiet_ticks[i] = 0;
        end
        thr_enter    = CFG_RESET.enter_level;
        thr_debounce = CFG_RESET.debounce_count;
        thr_leave    = CFG_RESET.leave_level;
        lost_after   = CFG_RESET.loss_timeout_ticks;
        tag_addr[0]  = CFG_RESET.beacon_addr[0];
        tag_addr[1]  = CFG_RESET.beacon_addr[1];
        addr_a = CFG_RESET.beacon_addr[0];
        addr_b = CFG_RESET.beacon_addr[1];
        blank  = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: misses and a tick leave everything at zero
        plan.push_back(pin(word_row(OP_ADVERT, '0, 8'h00), blank));
        plan.push_back(pin(word_row(OP_ADVERT, '1, 8'hFF), blank));
        plan.push_back(pin(word_row(OP_TICK, '1, 8'hFF), blank));
        // strong signal walks the average down to zero, beacon A turns present
        repeat (8) plan.push_back(word_row(OP_ADVERT, addr_a, 8'h00));
        repeat (6) plan.push_back(word_row(OP_ADVERT, addr_b, 8'h00));
        // counters now sit above a lowered debounce
        plan.push_back(cfg_row(REG_DEBOUNCE, 48'd1));
        plan.push_back(word_row(OP_ADVERT, addr_a, 8'h80));
        // both tracked addresses equal: lower index takes it
        plan.push_back(cfg_row(REG_BEACON_ADDR_B, addr_a));
        plan.push_back(word_row(OP_ADVERT, addr_a, 8'h01));
        // zero timeout loses every beacon on each tick
        plan.push_back(cfg_row(REG_LOSS_TIMEOUT, 48'd0));
        plan.push_back(word_row(OP_TICK, '0, 8'h00));
        plan.push_back(word_row(OP_ADVERT, addr_a, 8'h01));
        plan.push_back(word_row(OP_TICK, 48'h5555_5555_5555, 8'hAA));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
                cfg_we <= 1'b0;
            end else begin
                send_word(plan[i].word, plan[i].pinned, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                1: begin
                    ent = 8'd255; deb = 8'd0; lev = 8'd255; tmo = 16'hFFFF;
                    aa = '1; ab = '0;
                end
                2: begin
                    ent = 8'd0; deb = 8'd255; lev = 8'd0; tmo = 16'd1;
                    aa = rand_addr(); ab = aa;
                end
                3: begin
                    ent = CFG_RESET.enter_level;
                    deb = CFG_RESET.debounce_count;
                    lev = CFG_RESET.leave_level;
                    tmo = CFG_RESET.loss_timeout_ticks;
                    aa  = CFG_RESET.beacon_addr[0];
                    ab  = CFG_RESET.beacon_addr[1];
                end
                default: begin
                    ent  = 8'($urandom_range(20, 140));
                    deb  = 8'($urandom_range(0, 6));
                    lvl  = ent + $urandom_range(0, 50);
                    lev  = (lvl > 255) ? 8'd255 : 8'(lvl);
                    pick = $urandom_range(0, 5);
                    tmo  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF
                                                             : 16'($urandom_range(1, 60));
                    aa = rand_addr();
                    ab = ($urandom_range(0, 7) == 0) ? aa : rand_addr();
                end
            endcase
            write_reg(REG_ENTER_LEVEL, 48'(ent));
            write_reg(REG_DEBOUNCE, 48'(deb));
            write_reg(REG_LEAVE_LEVEL, 48'(lev));
            write_reg(REG_LOSS_TIMEOUT, 48'(tmo));
            write_reg(REG_BEACON_ADDR_A, aa);
            write_reg(REG_BEACON_ADDR_B, ab);
            cfg_we <= 1'b0;
            steady = (p == 4);
            trend[0] = ent;
            trend[1] = ent;

            repeat (PHASE_WORDS) begin
                pick       = $urandom_range(0, 99);
                w.op       = OP_ADVERT;
                w.mac      = rand_addr();
                w.rssi_raw = 8'($urandom_range(0, 255));
                if (pick < 64) begin
                    b     = (pick < 34) ? 0 : 1;
                    w.mac = (b == 0) ? aa : ab;
                    trend[b] += $urandom_range(0, 16) - 8;
                    if (trend[b] < 0) trend[b] = 0;
                    if (trend[b] > 255) trend[b] = 255;
                    if ($urandom_range(0, 9) < 7) begin
                        lvl = trend[b] + $urandom_range(0, 12) - 6;
                        if (lvl < 0) lvl = 0;
                        if (lvl > 255) lvl = 255;
                        w.rssi_raw = 8'd0 - 8'(lvl);
                    end
                end else if (pick < 84) begin
                    w.op = OP_TICK;
                end else if (pick >= 94) begin
                    w.mac = aa ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
                end
                send_word(w, 1'b0, blank);
            end
        end
        steady = 1'b0;

        settle();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
